// ===== rtl/assert_macros.svh =====
// Assertion macros used by the route table engine controller.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rte_pkg.sv =====
// ----------------------------------------------------------------------------
// rte_pkg
// Types, codes and constants of the route table engine.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPAIR_MASK    = 2'd2;

    localparam logic [CFG_W-1:0] ACTIVE_TIMEOUT_RST = 16'd3000;
    localparam logic [CFG_W-1:0] DELETE_PERIOD_RST  = 16'd15000;
    localparam logic [CFG_W-1:0] REPAIR_MASK_RST    = 16'd2;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_FIND       = 3'd1;
    localparam logic [2:0] OP_UPDATE     = 3'd2;
    localparam logic [2:0] OP_INVALIDATE = 3'd3;
    localparam logic [2:0] OP_DELETE     = 3'd4;
    localparam logic [2:0] OP_TICK       = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic VALID   = 1'b1;
    localparam logic INVALID = 1'b0;

    // Route table slot, one per way of a bucket row.
    typedef struct packed {
        logic        used;
        logic [31:0] key;
        logic [31:0] gateway;
        logic [7:0]  hops;
        logic [31:0] seqno;
        logic [15:0] flags;
        logic        valid;
        logic [31:0] deadline;
        logic        armed;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath.
    typedef struct packed {
        logic ready;
        logic hash_start;
        logic rd_en;
        logic exec;
        logic clear_en;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic req_valid;
        logic hash_done;
        logic out_free;
        logic clear_last;
    } ctrl_stat_t;

endpackage

// ===== rtl/rte_if.sv =====
// ----------------------------------------------------------------------------
// rte_req_if / rte_rsp_if
// Request and result channels of the route table engine.
// ----------------------------------------------------------------------------
interface rte_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] dest_key;
    logic [31:0] gateway;
    logic [7:0]  hop_count;
    logic [31:0] seq_number;
    logic [31:0] lifetime;
    logic        make_valid;
    logic [15:0] route_flags;

    modport source (output valid, opcode, dest_key, gateway, hop_count, seq_number,
                    lifetime, make_valid, route_flags, input ready);
    modport sink   (input valid, opcode, dest_key, gateway, hop_count, seq_number,
                    lifetime, make_valid, route_flags, output ready);
endinterface

interface rte_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] found_gateway;
    logic [7:0]  found_hops;
    logic [31:0] found_seqno;
    logic [15:0] found_flags;
    logic        route_valid;
    logic        timer_armed;
    logic        deadline_passed;
    logic [8:0]  entry_count;
    logic [8:0]  active_count;

    modport source (output valid, status, found_gateway, found_hops, found_seqno,
                    found_flags, route_valid, timer_armed, deadline_passed, entry_count,
                    active_count, input ready);
    modport sink   (input valid, status, found_gateway, found_hops, found_seqno,
                    found_flags, route_valid, timer_armed, deadline_passed, entry_count,
                    active_count, output ready);
endinterface

// ===== rtl/rte_ram.sv =====
// ----------------------------------------------------------------------------
// rte_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rte_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rte_hash.sv =====
// ----------------------------------------------------------------------------
// rte_hash
// Bucket index: key modulo BUCKETS. Low bits for a power of two, else a
// reciprocal multiplication with one correction step, product and remainder registered.
// ----------------------------------------------------------------------------
module rte_hash #(
    parameter int BUCKETS = rte_pkg::BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                key,
    output logic [$clog2(BUCKETS)-1:0] idx,
    output logic                       done
);

    localparam int BKT_W = $clog2(BUCKETS);

    if ((BUCKETS & (BUCKETS - 1)) == 0)
    begin : g_mask
        // index is always ready straight from the key bits
        assign idx  = key[BKT_W-1:0];
        assign done = 1'b1;
    end
    else
    begin : g_recip
        // floor(2^32 / BUCKETS); the quotient estimate is low by at most one
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
        localparam logic [31:0] BKT_N = 32'(BUCKETS);

        logic [31:0]      key_reg;
        logic [63:0]      prod_reg;
        logic             step_reg;
        logic             done_reg;
        logic [BKT_W-1:0] rem_reg;
        logic [31:0]      quot;
        logic [31:0]      rem_raw;
        logic [31:0]      rem_fix;

        always_comb
        begin
            quot    = prod_reg[63:32];
            rem_raw = key_reg - (quot * BKT_N);
            // remainder estimate lies below twice the divisor: subtract once
            rem_fix = (rem_raw >= BKT_N) ? (rem_raw - BKT_N) : rem_raw;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                step_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            else
            begin
                step_reg <= start;
                done_reg <= step_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                key_reg  <= key;
                prod_reg <= {32'd0, key} * {32'd0, RECIP};
            end
            if (step_reg)
            begin
                rem_reg <= rem_fix[BKT_W-1:0];
            end
        end

        assign idx  = rem_reg;
        assign done = done_reg;
    end

endmodule

// ===== rtl/rte_dpath.sv =====
// ----------------------------------------------------------------------------
// rte_dpath
// Datapath: request register, bucket RAM, way compare, slot update,
// counters, clock and result register.
// ----------------------------------------------------------------------------
module rte_dpath #(
    parameter int BUCKETS = rte_pkg::BUCKETS_DEF,
    parameter int WAYS    = rte_pkg::WAYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rte_pkg::ctrl_cmd_t              cmd,
    output rte_pkg::ctrl_stat_t             stat,
    input  logic                            cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rte_pkg::CFG_W-1:0]       cfg_data,
    rte_req_if.sink                         request,
    rte_rsp_if.source                       result
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * rte_pkg::ENTRY_W;
    localparam int CNT_W = $clog2(BUCKETS * WAYS + 1);
    localparam int EW    = rte_pkg::ENTRY_W;

    // configuration
    logic [15:0] art_reg, dp_reg, mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            art_reg  <= rte_pkg::ACTIVE_TIMEOUT_RST;
            dp_reg   <= rte_pkg::DELETE_PERIOD_RST;
            mask_reg <= rte_pkg::REPAIR_MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rte_pkg::CFG_ACTIVE_TIMEOUT: art_reg  <= cfg_data;
                rte_pkg::CFG_DELETE_PERIOD:  dp_reg   <= cfg_data;
                rte_pkg::CFG_REPAIR_MASK:    mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // request register
    logic [2:0]  op_reg;
    logic [31:0] key_reg, nh_reg, seq_reg, life_reg;
    logic [7:0]  hops_reg;
    logic        mk_reg;
    logic [15:0] fl_reg;
    logic [BKT_W-1:0] bkt_reg;

    assign request.ready = cmd.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.hash_start)
        begin
            op_reg   <= request.opcode;
            key_reg  <= request.dest_key;
            nh_reg   <= request.gateway;
            hops_reg <= request.hop_count;
            seq_reg  <= request.seq_number;
            life_reg <= request.lifetime;
            mk_reg   <= request.make_valid;
            fl_reg   <= request.route_flags;
        end
    end

    // bucket index and RAM
    logic [BKT_W-1:0] hash_idx;
    logic             hash_done;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [ROW_W-1:0] row_rd, row_wr;
    logic             do_write;

    rte_hash #(.BUCKETS(BUCKETS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.hash_start),
        .key   (request.dest_key),
        .idx   (hash_idx),
        .done  (hash_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            bkt_reg <= hash_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    rte_ram #(.DATA_W(ROW_W), .DEPTH(BUCKETS)) u_ram (
        .clk   (clk),
        .we    (cmd.clear_en | (cmd.exec & do_write)),
        .waddr (cmd.clear_en ? clr_cnt_reg : bkt_reg),
        .wdata (cmd.clear_en ? {ROW_W{1'b0}} : row_wr),
        .re    (cmd.rd_en),
        .raddr (hash_idx),
        .rdata (row_rd)
    );

    // way compare and slot update
    rte_pkg::entry_t ent [WAYS];
    rte_pkg::entry_t old_e, new_e;
    logic [WAYS-1:0] hit, free;
    logic [WAY_W-1:0] hway, fway, sway;
    logic            hit_any, free_any, report;
    logic [2:0]      st;
    logic [31:0]     now_reg, nd, dl_diff, life_eff, rep_dl;
    logic [CNT_W-1:0] ent_cnt_reg, ent_cnt_next, act_cnt_reg, act_cnt_next;
    logic [31:0]     now_next;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            ent[w]  = row_rd[w*EW +: EW];
            hit[w]  = ent[w].used && (ent[w].key == key_reg);
            free[w] = !ent[w].used;
        end
        hway = '0;
        fway = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                hway = WAY_W'(w);
            end
            if (free[w])
            begin
                fway = WAY_W'(w);
            end
        end
        hit_any  = |hit;
        free_any = |free;
        sway     = (op_reg == rte_pkg::OP_INSERT && !hit_any) ? fway : hway;
        old_e    = ent[sway];
        new_e    = old_e;
        nd       = now_reg + life_reg;
        dl_diff  = old_e.deadline - nd;
        rep_dl   = ((old_e.flags & mask_reg) != 16'd0) ? {16'd0, art_reg} : {16'd0, dp_reg};
        life_eff = life_reg;
        st       = rte_pkg::ST_OK;
        report   = 1'b0;
        do_write = 1'b0;
        now_next = now_reg;
        ent_cnt_next = ent_cnt_reg;
        act_cnt_next = act_cnt_reg;

        priority if (op_reg == rte_pkg::OP_TICK)
        begin
            now_next = now_reg + 32'd1;
        end
        else if (op_reg > rte_pkg::OP_TICK)
        begin
            st = rte_pkg::ST_OK;
        end
        else if (op_reg == rte_pkg::OP_INSERT)
        begin
            priority if (hit_any)
            begin
                st     = rte_pkg::ST_DUPLICATE;
                report = 1'b1;
            end
            else if (!free_any)
            begin
                st = rte_pkg::ST_FULL;
            end
            else
            begin
                if (mk_reg == rte_pkg::INVALID)
                begin
                    life_eff = ((fl_reg & mask_reg) != 16'd0) ? {16'd0, art_reg}
                                                              : {16'd0, dp_reg};
                end
                else
                begin
                    act_cnt_next = act_cnt_reg + 1'b1;
                end
                new_e.used     = 1'b1;
                new_e.key      = key_reg;
                new_e.gateway  = nh_reg;
                new_e.hops     = hops_reg;
                new_e.seqno    = seq_reg;
                new_e.flags    = fl_reg;
                new_e.valid    = mk_reg;
                new_e.armed    = (life_eff != 32'd0);
                new_e.deadline = now_reg + life_eff;
                ent_cnt_next   = ent_cnt_reg + 1'b1;
                report         = 1'b1;
                do_write       = 1'b1;
            end
        end
        else if (!hit_any)
        begin
            st = rte_pkg::ST_NOT_FOUND;
        end
        else
        begin
            unique case (op_reg)
                rte_pkg::OP_FIND:
                begin
                    report = 1'b1;
                end
                rte_pkg::OP_UPDATE:
                begin
                    if (!old_e.valid && mk_reg)
                    begin
                        act_cnt_next = act_cnt_reg + 1'b1;
                    end
                    else if (old_e.valid && !mk_reg && act_cnt_reg != '0)
                    begin
                        act_cnt_next = act_cnt_reg - 1'b1;
                    end
                    new_e.seqno    = seq_reg;
                    new_e.flags    = fl_reg;
                    new_e.gateway  = nh_reg;
                    new_e.hops     = hops_reg;
                    if (old_e.valid && old_e.armed)
                    begin
                        // keep the later deadline
                        if (dl_diff[31])
                        begin
                            new_e.deadline = nd;
                        end
                    end
                    else
                    begin
                        new_e.deadline = nd;
                        new_e.armed    = 1'b1;
                    end
                    new_e.valid = mk_reg;
                    report      = 1'b1;
                    do_write    = 1'b1;
                end
                rte_pkg::OP_INVALIDATE:
                begin
                    if (!old_e.valid)
                    begin
                        new_e.armed = 1'b0;
                        st          = rte_pkg::ST_INVALID;
                    end
                    else
                    begin
                        new_e.valid = rte_pkg::INVALID;
                        if (act_cnt_reg != '0)
                        begin
                            act_cnt_next = act_cnt_reg - 1'b1;
                        end
                        new_e.seqno    = old_e.seqno + 32'd1;
                        new_e.deadline = now_reg + rep_dl;
                        new_e.armed    = 1'b1;
                    end
                    report   = 1'b1;
                    do_write = 1'b1;
                end
                default:
                begin
                    // delete
                    if (old_e.valid && act_cnt_reg != '0)
                    begin
                        act_cnt_next = act_cnt_reg - 1'b1;
                    end
                    if (ent_cnt_reg != '0)
                    begin
                        ent_cnt_next = ent_cnt_reg - 1'b1;
                    end
                    new_e.used  = 1'b0;
                    new_e.armed = 1'b0;
                    new_e.valid = rte_pkg::INVALID;
                    do_write    = 1'b1;
                end
            endcase
        end

        row_wr = row_rd;
        row_wr[sway*EW +: EW] = new_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            ent_cnt_reg <= '0;
            act_cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            now_reg     <= now_next;
            ent_cnt_reg <= ent_cnt_next;
            act_cnt_reg <= act_cnt_next;
        end
    end

    // result register
    logic        out_valid_reg;
    logic [31:0] pass_diff;
    logic [2:0]  r_status_reg;
    logic [31:0] r_nh_reg, r_seq_reg;
    logic [7:0]  r_hops_reg;
    logic [15:0] r_fl_reg;
    logic        r_valid_reg, r_armed_reg, r_pass_reg;
    logic [8:0]  r_ent_reg, r_act_reg;

    assign pass_diff = now_reg - new_e.deadline;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            r_status_reg <= st;
            r_nh_reg     <= report ? new_e.gateway : 32'd0;
            r_hops_reg   <= report ? new_e.hops : 8'd0;
            r_seq_reg    <= report ? new_e.seqno : 32'd0;
            r_fl_reg     <= report ? new_e.flags : 16'd0;
            r_valid_reg  <= report & new_e.valid;
            r_armed_reg  <= report & new_e.armed;
            r_pass_reg   <= report & new_e.armed & ~pass_diff[31];
            r_ent_reg    <= 9'(ent_cnt_next);
            r_act_reg    <= 9'(act_cnt_next);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = r_status_reg;
    assign result.found_gateway   = r_nh_reg;
    assign result.found_hops      = r_hops_reg;
    assign result.found_seqno     = r_seq_reg;
    assign result.found_flags     = r_fl_reg;
    assign result.route_valid     = r_valid_reg;
    assign result.timer_armed     = r_armed_reg;
    assign result.deadline_passed = r_pass_reg;
    assign result.entry_count     = r_ent_reg;
    assign result.active_count    = r_act_reg;

    assign stat.req_valid  = request.valid;
    assign stat.hash_done  = hash_done;
    assign stat.out_free   = !out_valid_reg || result.ready;
    assign stat.clear_last = (clr_cnt_reg == BKT_W'(BUCKETS - 1));

endmodule

// ===== rtl/rte_ctrl.sv =====
// ----------------------------------------------------------------------------
// rte_ctrl
// Controller: clearing pass, request accept, bucket read, execute.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  rte_pkg::ctrl_stat_t stat,
    output rte_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_HASH  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ready      = 1'b1;
                cmd.hash_start = stat.req_valid;
                if (stat.req_valid)
                begin
                    if (stat.hash_done)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (stat.hash_done)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RTE_ASSERT_NXT(a_read_then_exec, cmd.rd_en, state_reg == S_EXEC, "read not followed by execute")
    `RTE_ASSERT_IMP(a_one_ram_use, 1'b1, $onehot0({cmd.rd_en, cmd.exec, cmd.clear_en}), "RAM commands overlap")
    `RTE_ASSERT_IMP(a_exec_room, cmd.exec, stat.out_free, "execute with result register full")
    `RTE_ASSERT_IMP(a_no_accept_clear, cmd.clear_en, !cmd.ready, "request taken during clear")

endmodule

// ===== rtl/route_table_engine.sv =====
// ----------------------------------------------------------------------------
// route_table_engine
// Hashed route table with route lifetimes, top level.
// ----------------------------------------------------------------------------
// The table holds BUCKETS rows of WAYS slots in one RAM; a request picks the
// row by dest_key modulo BUCKETS and compares all ways at once. After reset
// the block runs a clearing pass (one row per cycle) and takes no request
// until it is done; configuration writes are taken at any time the block is
// idle. With BUCKETS a power of two a request goes from the registered RAM
// read of the bucket row to the execute step, which compares keys, writes
// the row back and loads the result register. For other bucket counts the
// row index first comes from a two-stage reciprocal multiplication. The
// result register decouples the output: a new request is taken while a
// result still waits, and execution holds only if the previous result has
// not been taken yet.
// ----------------------------------------------------------------------------
module route_table_engine #(
    parameter int BUCKETS = rte_pkg::BUCKETS_DEF,
    parameter int WAYS    = rte_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rte_pkg::CFG_W-1:0]     cfg_data,
    rte_req_if.sink                       request,
    rte_rsp_if.source                     result
);

    // command and status between controller and datapath
    rte_pkg::ctrl_cmd_t  cmd;
    rte_pkg::ctrl_stat_t stat;

    // sequencing: clear, accept, read row, execute
    rte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // table storage, compare, update and result register
    rte_dpath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .result    (result)
    );

endmodule
